// ===== design/lli_pkg.sv =====
// shared types, widths and helpers for the two-line intersection block
package lli_pkg;

  localparam int CoordBits = 32;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int NdW       = ProdW + 1;
  localparam int LoW       = NdW / 2 + 1;
  localparam int HiW       = NdW - LoW;
  localparam int PpW       = DiffW + LoW;
  localparam int FullW     = NdW + DiffW;
  localparam int QuoBits   = DiffW;
  localparam int SumW      = QuoBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;
  typedef logic signed [ProdW-1:0]     prod_t;
  typedef logic signed [NdW-1:0]       nd_t;
  typedef logic        [NdW-1:0]       ndmag_t;
  typedef logic        [DiffW-1:0]     dmag_t;
  typedef logic        [PpW-1:0]       pp_t;
  typedef logic        [FullW-1:0]     full_t;
  typedef logic        [QuoBits-1:0]   quo_t;
  typedef logic signed [SumW-1:0]      sum_t;

  typedef struct packed {
    coord_t line_one_start_x;
    coord_t line_one_start_y;
    coord_t line_one_end_x;
    coord_t line_one_end_y;
    coord_t line_two_start_x;
    coord_t line_two_start_y;
    coord_t line_two_end_x;
    coord_t line_two_end_y;
  } lli_seg_t;

  typedef struct packed {
    coord_t a1x;
    coord_t a1y;
    diff_t  d1x;
    diff_t  d1y;
    nd_t    num;
    nd_t    den;
  } lli_nd_t;

  // one divider lane per coordinate
  typedef struct packed {
    full_t rem;
    quo_t  quo;
    logic  neg;
    logic  big;
  } lli_lane_t;

  typedef struct packed {
    coord_t    a1x;
    coord_t    a1y;
    full_t     dsh;
    logic      par;
    lli_lane_t lx;
    lli_lane_t ly;
  } lli_div_t;

  typedef struct packed {
    coord_t cross_x;
    coord_t cross_y;
    logic   parallel_flag;
    logic   saturated_flag;
  } lli_pt_t;

  typedef struct packed {
    coord_t val;
    logic   sat;
  } lli_clamp_t;

  localparam sum_t SumMax = sum_t'({1'b0, {(CoordBits-1){1'b1}}});
  localparam sum_t SumMin = -SumMax - sum_t'(1);

  function automatic lli_clamp_t coord_out(input coord_t a1, input lli_lane_t ln);
    lli_clamp_t r;
    sum_t       q;
    sum_t       s;
    q = sum_t'({2'b00, ln.quo});
    s = sum_t'(a1) + (ln.neg ? -q : q);
    r.sat = 1'b1;
    if (ln.big) begin
      r.val = ln.neg ? coord_t'(SumMin) : coord_t'(SumMax);
    end else if (s > SumMax) begin
      r.val = coord_t'(SumMax);
    end else if (s < SumMin) begin
      r.val = coord_t'(SumMin);
    end else begin
      r.val = coord_t'(s);
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/lli_if.sv =====
// valid/ready channel interfaces for line pairs and intersection points
interface lli_seg_if;
  logic                   valid;
  logic                   ready;
  lli_pkg::coord_t        line_one_start_x;
  lli_pkg::coord_t        line_one_start_y;
  lli_pkg::coord_t        line_one_end_x;
  lli_pkg::coord_t        line_one_end_y;
  lli_pkg::coord_t        line_two_start_x;
  lli_pkg::coord_t        line_two_start_y;
  lli_pkg::coord_t        line_two_end_x;
  lli_pkg::coord_t        line_two_end_y;

  modport source (output valid, line_one_start_x, line_one_start_y, line_one_end_x,
                  line_one_end_y, line_two_start_x, line_two_start_y, line_two_end_x,
                  line_two_end_y, input ready);
  modport sink (input valid, line_one_start_x, line_one_start_y, line_one_end_x,
                line_one_end_y, line_two_start_x, line_two_start_y, line_two_end_x,
                line_two_end_y, output ready);
endinterface

interface lli_pt_if;
  logic            valid;
  logic            ready;
  lli_pkg::coord_t cross_x;
  lli_pkg::coord_t cross_y;
  logic            parallel_flag;
  logic            saturated_flag;

  modport source (output valid, cross_x, cross_y, parallel_flag, saturated_flag,
                  input ready);
  modport sink (input valid, cross_x, cross_y, parallel_flag, saturated_flag,
                output ready);
endinterface

// ===== design/line_line_intersect_2d_top.sv =====
// two-line intersection top level: front end, multiplier, divider chain, output
//
//   channel  dir  handshake     payload
//   segs     in   valid/ready   two line segments, eight signed Q16.16 coords
//   point    out  valid/ready   cross_x, cross_y, parallel_flag, saturated_flag
//
// one line pair per cycle while the result is not stalled, 41 register stages from accept to result
// the 33 one-bit restoring divider stages follow 7 arithmetic stages
// synchronous reset clears all stage valid bits; data registers are not reset
// a stalled result holds the whole pipeline, nothing is dropped or repeated
module line_line_intersect_2d_top (
  input  logic       clk,
  input  logic       rst,
  lli_seg_if.sink    segs,
  lli_pt_if.source   point
);

  logic              en;
  lli_pkg::lli_seg_t seg;
  logic              nd_valid;
  lli_pkg::lli_nd_t  nd;
  logic              dv [lli_pkg::QuoBits+1];
  lli_pkg::lli_div_t dd [lli_pkg::QuoBits+1];
  lli_pkg::lli_clamp_t cx, cy;
  lli_pkg::lli_pt_t  pt;

  assign en         = !point.valid || point.ready;
  assign segs.ready = en;

  assign seg.line_one_start_x = segs.line_one_start_x;
  assign seg.line_one_start_y = segs.line_one_start_y;
  assign seg.line_one_end_x   = segs.line_one_end_x;
  assign seg.line_one_end_y   = segs.line_one_end_y;
  assign seg.line_two_start_x = segs.line_two_start_x;
  assign seg.line_two_start_y = segs.line_two_start_y;
  assign seg.line_two_end_x   = segs.line_two_end_x;
  assign seg.line_two_end_y   = segs.line_two_end_y;

  lli_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .seg_valid(segs.valid), .seg(seg),
    .nd_valid(nd_valid), .nd(nd)
  );

  lli_mul u_mul (
    .clk(clk), .rst(rst), .en(en),
    .nd_valid(nd_valid), .nd(nd),
    .div_valid(dv[0]), .div(dd[0])
  );

  for (genvar k = 0; k < lli_pkg::QuoBits; k++) begin : g_div
    lli_div_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[k]), .din(dd[k]),
      .out_valid(dv[k+1]), .dout(dd[k+1])
    );
  end

  assign cx = lli_pkg::coord_out(dd[lli_pkg::QuoBits].a1x, dd[lli_pkg::QuoBits].lx);
  assign cy = lli_pkg::coord_out(dd[lli_pkg::QuoBits].a1y, dd[lli_pkg::QuoBits].ly);

  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (en) begin
      point.valid <= dv[lli_pkg::QuoBits];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dd[lli_pkg::QuoBits].par) begin
        pt.cross_x        <= '0;
        pt.cross_y        <= '0;
        pt.parallel_flag  <= 1'b1;
        pt.saturated_flag <= 1'b0;
      end else begin
        pt.cross_x        <= cx.val;
        pt.cross_y        <= cy.val;
        pt.parallel_flag  <= 1'b0;
        pt.saturated_flag <= cx.sat || cy.sat;
      end
    end
  end

  assign point.cross_x        = pt.cross_x;
  assign point.cross_y        = pt.cross_y;
  assign point.parallel_flag  = pt.parallel_flag;
  assign point.saturated_flag = pt.saturated_flag;

`ifndef SYNTHESIS
  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.parallel_flag |->
      point.cross_x == '0 && point.cross_y == '0 && !point.saturated_flag)
    else $error("parallel result carries nonzero data");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    point.valid && !point.ready |-> !segs.ready)
    else $error("input taken while result stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !point.valid)
    else $error("result valid after reset");
`endif

endmodule

// ===== design/lli_front.sv =====
// direction vectors, cross products and numerator/denominator, three stages
module lli_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             seg_valid,
  input  lli_pkg::lli_seg_t seg,
  output logic             nd_valid,
  output lli_pkg::lli_nd_t nd
);

  logic            v1, v2;
  lli_pkg::coord_t a1x1, a1y1, a1x2, a1y2;
  lli_pkg::diff_t  d1x1, d1y1, d2x1, d2y1, ayd1, axd1;
  lli_pkg::diff_t  d1x2, d1y2;
  lli_pkg::prod_t  pn0, pn1, pd0, pd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      nd_valid <= 1'b0;
    end else if (en) begin
      v1       <= seg_valid;
      v2       <= v1;
      nd_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1x1 <= seg.line_one_start_x;
      a1y1 <= seg.line_one_start_y;
      d1x1 <= lli_pkg::diff_t'(seg.line_one_end_x) - lli_pkg::diff_t'(seg.line_one_start_x);
      d1y1 <= lli_pkg::diff_t'(seg.line_one_end_y) - lli_pkg::diff_t'(seg.line_one_start_y);
      d2x1 <= lli_pkg::diff_t'(seg.line_two_end_x) - lli_pkg::diff_t'(seg.line_two_start_x);
      d2y1 <= lli_pkg::diff_t'(seg.line_two_end_y) - lli_pkg::diff_t'(seg.line_two_start_y);
      ayd1 <= lli_pkg::diff_t'(seg.line_two_start_y) - lli_pkg::diff_t'(seg.line_one_start_y);
      axd1 <= lli_pkg::diff_t'(seg.line_two_start_x) - lli_pkg::diff_t'(seg.line_one_start_x);

      a1x2 <= a1x1;
      a1y2 <= a1y1;
      d1x2 <= d1x1;
      d1y2 <= d1y1;
      pn0  <= lli_pkg::prod_t'(d2x1) * lli_pkg::prod_t'(ayd1);
      pn1  <= lli_pkg::prod_t'(d2y1) * lli_pkg::prod_t'(axd1);
      pd0  <= lli_pkg::prod_t'(d2x1) * lli_pkg::prod_t'(d1y1);
      pd1  <= lli_pkg::prod_t'(d2y1) * lli_pkg::prod_t'(d1x1);

      nd.a1x <= a1x2;
      nd.a1y <= a1y2;
      nd.d1x <= d1x2;
      nd.d1y <= d1y2;
      nd.num <= lli_pkg::nd_t'(pn0) - lli_pkg::nd_t'(pn1);
      nd.den <= lli_pkg::nd_t'(pd0) - lli_pkg::nd_t'(pd1);
    end
  end

endmodule

// ===== design/lli_mul.sv =====
// magnitudes, split product direction*numerator, overflow check, divider setup
module lli_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              nd_valid,
  input  lli_pkg::lli_nd_t  nd,
  output logic              div_valid,
  output lli_pkg::lli_div_t div
);

  logic             v4, v5, v6;
  lli_pkg::coord_t  a1x4, a1y4, a1x5, a1y5, a1x6, a1y6;
  lli_pkg::ndmag_t  nmag4, dmag4, dmag5, dmag6;
  lli_pkg::dmag_t   xm4, ym4;
  logic             negx4, negy4, par4, negx5, negy5, par5, negx6, negy6, par6;
  lli_pkg::pp_t     xl5, xh5, yl5, yh5;
  lli_pkg::full_t   px6, py6, dtop;

  assign dtop = {dmag6, lli_pkg::QuoBits'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      div_valid <= 1'b0;
    end else if (en) begin
      v4        <= nd_valid;
      v5        <= v4;
      v6        <= v5;
      div_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1x4  <= nd.a1x;
      a1y4  <= nd.a1y;
      nmag4 <= nd.num[lli_pkg::NdW-1] ? lli_pkg::ndmag_t'(-nd.num) : lli_pkg::ndmag_t'(nd.num);
      dmag4 <= nd.den[lli_pkg::NdW-1] ? lli_pkg::ndmag_t'(-nd.den) : lli_pkg::ndmag_t'(nd.den);
      xm4   <= nd.d1x[lli_pkg::DiffW-1] ? lli_pkg::dmag_t'(-nd.d1x) : lli_pkg::dmag_t'(nd.d1x);
      ym4   <= nd.d1y[lli_pkg::DiffW-1] ? lli_pkg::dmag_t'(-nd.d1y) : lli_pkg::dmag_t'(nd.d1y);
      negx4 <= nd.d1x[lli_pkg::DiffW-1] ^ nd.num[lli_pkg::NdW-1] ^ nd.den[lli_pkg::NdW-1];
      negy4 <= nd.d1y[lli_pkg::DiffW-1] ^ nd.num[lli_pkg::NdW-1] ^ nd.den[lli_pkg::NdW-1];
      par4  <= (nd.den == '0);

      a1x5  <= a1x4;
      a1y5  <= a1y4;
      dmag5 <= dmag4;
      negx5 <= negx4;
      negy5 <= negy4;
      par5  <= par4;
      xl5   <= lli_pkg::pp_t'(xm4) * lli_pkg::pp_t'(nmag4[lli_pkg::LoW-1:0]);
      xh5   <= lli_pkg::pp_t'(xm4) * lli_pkg::pp_t'(nmag4[lli_pkg::NdW-1:lli_pkg::LoW]);
      yl5   <= lli_pkg::pp_t'(ym4) * lli_pkg::pp_t'(nmag4[lli_pkg::LoW-1:0]);
      yh5   <= lli_pkg::pp_t'(ym4) * lli_pkg::pp_t'(nmag4[lli_pkg::NdW-1:lli_pkg::LoW]);

      a1x6  <= a1x5;
      a1y6  <= a1y5;
      dmag6 <= dmag5;
      negx6 <= negx5;
      negy6 <= negy5;
      par6  <= par5;
      px6   <= lli_pkg::full_t'({xh5, lli_pkg::LoW'(0)}) + lli_pkg::full_t'(xl5);
      py6   <= lli_pkg::full_t'({yh5, lli_pkg::LoW'(0)}) + lli_pkg::full_t'(yl5);

      // quotient at or above 2^QuoBits always saturates
      div.a1x    <= a1x6;
      div.a1y    <= a1y6;
      div.par    <= par6;
      div.dsh    <= dtop >> 1;
      div.lx.rem <= px6;
      div.lx.quo <= '0;
      div.lx.neg <= negx6;
      div.lx.big <= (px6 >= dtop);
      div.ly.rem <= py6;
      div.ly.quo <= '0;
      div.ly.neg <= negy6;
      div.ly.big <= (py6 >= dtop);
    end
  end

endmodule

// ===== design/lli_div_step.sv =====
// one restoring divider stage: one quotient bit for each coordinate
module lli_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  lli_pkg::lli_div_t din,
  output logic              out_valid,
  output lli_pkg::lli_div_t dout
);

  logic              gex, gey;
  lli_pkg::lli_div_t dout_next;

  assign gex = (din.lx.rem >= din.dsh);
  assign gey = (din.ly.rem >= din.dsh);

  always_comb begin
    dout_next        = din;
    dout_next.dsh    = din.dsh >> 1;
    dout_next.lx.rem = gex ? din.lx.rem - din.dsh : din.lx.rem;
    dout_next.lx.quo = {din.lx.quo[lli_pkg::QuoBits-2:0], gex};
    dout_next.ly.rem = gey ? din.ly.rem - din.dsh : din.ly.rem;
    dout_next.ly.quo = {din.ly.quo[lli_pkg::QuoBits-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule
